[hdl/fcw_pkg.sv]
// ----------------------------------------------------------------------------
// FAT12 chain walker package
// Request modes, chain status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fcw_pkg;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;

   localparam logic [1:0] STATUS_MORE     = 2'd0;
   localparam logic [1:0] STATUS_END      = 2'd1;
   localparam logic [1:0] STATUS_BAD      = 2'd2;
   localparam logic [1:0] STATUS_INACTIVE = 2'd3;

   localparam logic REG_DATA_START  = 1'b0;
   localparam logic REG_SECTORS_PER = 1'b1;

   localparam logic [11:0] CLUSTER_BAD       = 12'hFF7;
   localparam logic [11:0] CLUSTER_END_FIRST = 12'hFF8;

   localparam logic [31:0] DATA_START_RESET  = 32'd33;
   localparam logic [7:0]  SECTORS_PER_RESET = 8'd1;

endpackage

`default_nettype wire

[hdl/fcw_if.sv]
// ----------------------------------------------------------------------------
// FAT12 chain walker channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [12:0] byte_address;
   logic [7:0]  byte_value;
   logic [11:0] first_cluster;

   modport source (output valid, mode, byte_address, byte_value, first_cluster,
                   input ready);
   modport sink (input valid, mode, byte_address, byte_value, first_cluster,
                 output ready);
endinterface

interface fcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sector_address;
   logic [11:0] this_cluster;
   logic [11:0] next_cluster;
   logic [1:0]  chain_status;

   modport source (output valid, sector_address, this_cluster, next_cluster,
                   chain_status, input ready);
   modport sink (input valid, sector_address, this_cluster, next_cluster,
                 chain_status, output ready);
endinterface

interface fcw_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/fcw_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access a cycle, write or registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 3072
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else if (en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hdl/fat12_cluster_chain_walker.sv]
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker
// Holds a packed FAT12 table in two byte banks and walks one cluster chain.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req_if   in   mode, byte_address, byte_value, first_cluster
//  rsp_if   out  sector_address, this_cluster, next_cluster, chain_status
//  csr_if   in   index, data (0 data start sector, 1 sectors per cluster)
//
//  Load and unused-mode requests finish when accepted; start and step go through
//  the table banks' registered read, then decode into the response register.
//  Even and odd bytes sit in separate banks so both entry bytes come in one read.
//  Start and step wait in the decode state while the response register is held.
//  Reset clears the chain and restores register defaults; the table is not
//  cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_chain_walker #(
   parameter int TABLE_BYTES = 6144
) (
   input wire logic clock,
   input wire logic reset,
   fcw_req_if.sink   req_if,
   fcw_rsp_if.source rsp_if,
   fcw_csr_if.sink   csr_if
);

   localparam int EVEN_DEPTH = (TABLE_BYTES + 1) / 2;
   localparam int ODD_DEPTH  = TABLE_BYTES / 2;
   localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
   localparam int ODD_AW     = $clog2(ODD_DEPTH);

   typedef enum logic {ST_IDLE, ST_LOOKUP} state_type;

   state_type   state_ff, state_in;
   logic [31:0] data_start_ff, data_start_in;
   logic [7:0]  sectors_per_ff, sectors_per_in;
   logic [11:0] cur_cluster_ff, cur_cluster_in;
   logic        active_ff, active_in;
   logic [11:0] cl_ff, cl_in;
   logic        lk_active_ff, lk_active_in;
   logic        idx_odd_ff, idx_odd_in;
   logic        lo_ok_ff, lo_ok_in;
   logic        hi_ok_ff, hi_ok_in;
   logic [31:0] prod_ff, prod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_sector_ff, rsp_sector_in;
   logic [11:0] rsp_this_ff, rsp_this_in;
   logic [11:0] rsp_next_ff, rsp_next_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic        accept, is_load, is_lookup, ld_ok;
   logic [11:0] ld_row;
   logic [11:0] cl_sel;
   logic [13:0] idx, idx_hi, row, row_up;
   logic signed [12:0] cl_m2;
   logic signed [21:0] prod;
   logic        even_en, odd_en, even_we, odd_we;
   logic [EVEN_AW-1:0] even_addr;
   logic [ODD_AW-1:0]  odd_addr;
   logic [7:0]  even_rdata, odd_rdata, lo_byte, hi_byte;
   logic [15:0] pair;
   logic [11:0] next_cl;
   logic [1:0]  status;
   logic        out_free;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;
   assign is_load      = (req_if.mode == fcw_pkg::MODE_LOAD);
   assign is_lookup    = (req_if.mode == fcw_pkg::MODE_START) ||
                         (req_if.mode == fcw_pkg::MODE_STEP);

   // table write
   assign ld_ok   = ({19'd0, req_if.byte_address} < 32'(TABLE_BYTES));
   assign ld_row  = req_if.byte_address[12:1];
   assign even_we = accept && is_load && ld_ok && !req_if.byte_address[0];
   assign odd_we  = accept && is_load && ld_ok && req_if.byte_address[0];

   // entry address: cluster * 3 / 2
   assign cl_sel = (req_if.mode == fcw_pkg::MODE_START) ? req_if.first_cluster
                                                        : cur_cluster_ff;
   assign idx    = 14'(({2'd0, cl_sel} + {1'b0, cl_sel, 1'b0}) >> 1);
   assign idx_hi = idx + 14'd1;
   assign row    = idx >> 1;
   assign row_up = row + 14'd1;

   assign even_en   = accept && is_lookup;
   assign odd_en    = accept && is_lookup;
   assign even_addr = is_load ? ld_row[EVEN_AW-1:0]
                              : (idx[0] ? row_up[EVEN_AW-1:0] : row[EVEN_AW-1:0]);
   assign odd_addr  = is_load ? ld_row[ODD_AW-1:0] : row[ODD_AW-1:0];

   // (cluster - 2) * sectors per cluster, modulo 2^32
   assign cl_m2 = $signed({1'b0, cl_sel}) - 13'sd2;
   assign prod  = cl_m2 * $signed({1'b0, sectors_per_ff});

   fcw_ram #(.WIDTH(8), .DEPTH(EVEN_DEPTH)) u_even_bank (
      .clock (clock),
      .en    (even_en),
      .we    (even_we),
      .addr  (even_addr),
      .wdata (req_if.byte_value),
      .rdata (even_rdata)
   );

   fcw_ram #(.WIDTH(8), .DEPTH(ODD_DEPTH)) u_odd_bank (
      .clock (clock),
      .en    (odd_en),
      .we    (odd_we),
      .addr  (odd_addr),
      .wdata (req_if.byte_value),
      .rdata (odd_rdata)
   );

   // decode
   assign lo_byte = lo_ok_ff ? (idx_odd_ff ? odd_rdata : even_rdata) : 8'd0;
   assign hi_byte = hi_ok_ff ? (idx_odd_ff ? even_rdata : odd_rdata) : 8'd0;
   assign pair    = {hi_byte, lo_byte};
   assign next_cl = cl_ff[0] ? pair[15:4] : pair[11:0];

   always_comb begin
      if (next_cl >= fcw_pkg::CLUSTER_END_FIRST) begin
         status = fcw_pkg::STATUS_END;
      end else if (next_cl == fcw_pkg::CLUSTER_BAD) begin
         status = fcw_pkg::STATUS_BAD;
      end else begin
         status = fcw_pkg::STATUS_MORE;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in       = state_ff;
      data_start_in  = data_start_ff;
      sectors_per_in = sectors_per_ff;
      cur_cluster_in = cur_cluster_ff;
      active_in      = active_ff;
      cl_in          = cl_ff;
      lk_active_in   = lk_active_ff;
      idx_odd_in     = idx_odd_ff;
      lo_ok_in       = lo_ok_ff;
      hi_ok_in       = hi_ok_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_sector_in  = rsp_sector_ff;
      rsp_this_in    = rsp_this_ff;
      rsp_next_in    = rsp_next_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_if.valid) begin
         if (csr_if.index == fcw_pkg::REG_DATA_START) begin
            data_start_in = csr_if.data;
         end else begin
            sectors_per_in = csr_if.data[7:0];
         end
      end

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && is_lookup) begin
               cl_in        = cl_sel;
               lk_active_in = (req_if.mode == fcw_pkg::MODE_START) || active_ff;
               idx_odd_in   = idx[0];
               lo_ok_in     = ({18'd0, idx} < 32'(TABLE_BYTES));
               hi_ok_in     = ({18'd0, idx_hi} < 32'(TABLE_BYTES));
               prod_in      = {{10{prod[21]}}, prod};
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (lk_active_ff) begin
                  rsp_sector_in  = data_start_ff + prod_ff;
                  rsp_this_in    = cl_ff;
                  rsp_next_in    = next_cl;
                  rsp_status_in  = status;
                  cur_cluster_in = next_cl;
                  active_in      = (status == fcw_pkg::STATUS_MORE);
               end else begin
                  rsp_sector_in = 32'd0;
                  rsp_this_in   = 12'd0;
                  rsp_next_in   = 12'd0;
                  rsp_status_in = fcw_pkg::STATUS_INACTIVE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         data_start_ff  <= fcw_pkg::DATA_START_RESET;
         sectors_per_ff <= fcw_pkg::SECTORS_PER_RESET;
         cur_cluster_ff <= 12'd0;
         active_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         data_start_ff  <= data_start_in;
         sectors_per_ff <= sectors_per_in;
         cur_cluster_ff <= cur_cluster_in;
         active_ff      <= active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cl_ff         <= cl_in;
      lk_active_ff  <= lk_active_in;
      idx_odd_ff    <= idx_odd_in;
      lo_ok_ff      <= lo_ok_in;
      hi_ok_ff      <= hi_ok_in;
      prod_ff       <= prod_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_this_ff   <= rsp_this_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.sector_address = rsp_sector_ff;
   assign rsp_if.this_cluster   = rsp_this_ff;
   assign rsp_if.next_cluster   = rsp_next_ff;
   assign rsp_if.chain_status   = rsp_status_ff;

endmodule

`default_nettype wire
